>>> src/tia_pkg.sv
// Shared types and constants for the table interpolation block.
// Holds the table geometry, status and action codes, and the controller/datapath interface.
// No dependencies.
`default_nettype none

package tia_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int AW          = $clog2(TABLE_DEPTH);
	localparam int CW          = $clog2(TABLE_DEPTH + 1);
	localparam int KEY_W       = 32;
	localparam int VAL_W       = 16;
	localparam int WORD_W      = KEY_W + VAL_W;
	localparam int NUM_W       = KEY_W + VAL_W;
	localparam int ST_W        = 3;
	localparam int ACT_W       = 2;
	localparam int DCNT_W      = $clog2(VAL_W);

	localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_APPEND = 2'd1;
	localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd2;

	localparam logic [ST_W-1:0] ST_INTERP  = 3'd0;
	localparam logic [ST_W-1:0] ST_HOLD    = 3'd1;
	localparam logic [ST_W-1:0] ST_OUTSIDE = 3'd2;
	localparam logic [ST_W-1:0] ST_EMPTY   = 3'd3;
	localparam logic [ST_W-1:0] ST_STORED  = 3'd4;
	localparam logic [ST_W-1:0] ST_FULL    = 3'd5;
	localparam logic [ST_W-1:0] ST_CLEARED = 3'd6;

	localparam logic REG_LOW_HOLD  = 1'b0;
	localparam logic REG_HIGH_HOLD = 1'b1;

	localparam logic [KEY_W-1:0] LOW_HOLD_RESET  = 32'd2560000;
	localparam logic [KEY_W-1:0] HIGH_HOLD_RESET = 32'd51200000;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LATCH,
		OP_CLEAR,
		OP_APPEND,
		OP_BUMP,
		OP_INIT,
		OP_STEP,
		OP_LOAD_LO,
		OP_LOAD_HI,
		OP_PREP,
		OP_MUL1,
		OP_MUL2,
		OP_DIV_STEP
	} dp_op_t;

	typedef enum logic [2:0] {
		ADDR_FIRST,
		ADDR_LAST,
		ADDR_MID,
		ADDR_LO,
		ADDR_HI
	} addr_sel_t;

	typedef enum logic [1:0] {
		VAL_ZERO,
		VAL_RD,
		VAL_LO,
		VAL_QUOT
	} val_sel_t;

	typedef struct packed {
		dp_op_t          op;
		addr_sel_t       addr_sel;
		logic            finish;
		logic [ST_W-1:0] res_status;
		val_sel_t        val_sel;
	} tia_cmd_t;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic             n_zero;
		logic             n_one;
		logic             full;
		logic             t_gt_high;
		logic             t_lt_low;
		logic             t_gt_key;
		logic             t_lt_key;
		logic             search_done;
		logic             step_nonpos;
		logic             div_last;
	} tia_stat_t;

endpackage

`default_nettype wire

>>> src/tia_dpath.sv
// Datapath: table memory, search bounds, interpolation multiply and serial divider.
// Driven by tia_ctrl through tia_cmd_t; reports through tia_stat_t. Uses tia_pkg.
`default_nettype none

module tia_dpath (
	input  wire                       clk,
	input  wire                       arst_n,
	input  tia_pkg::tia_cmd_t         cmd,
	output tia_pkg::tia_stat_t        stat,
	input  wire  [1:0]                action,
	input  wire  [31:0]               temperature,
	input  wire  [15:0]               entry_value,
	input  wire                       wr_en,
	input  wire                       wr_index,
	input  wire  [31:0]               wr_data,
	output logic [15:0]               value_out,
	output logic [2:0]                status,
	output logic [31:0]               out_of_range_count
);
	import tia_pkg::*;

	logic [WORD_W-1:0] mem [TABLE_DEPTH];
	logic [WORD_W-1:0] rd_q;
	logic [AW-1:0]     rd_addr;
	logic [KEY_W-1:0]  rd_key;
	logic [VAL_W-1:0]  rd_val;

	logic [ACT_W-1:0]  action_q;
	logic [KEY_W-1:0]  t_q;
	logic [VAL_W-1:0]  v_q;
	logic [KEY_W-1:0]  low_q;
	logic [KEY_W-1:0]  high_q;
	logic [CW-1:0]     count_q;
	logic [KEY_W-1:0]  miss_q;
	logic [AW-1:0]     lo_q;
	logic [AW-1:0]     hi_q;
	logic [AW-1:0]     mid;
	logic [AW-1:0]     last_addr;
	logic [KEY_W-1:0]  klo_q;
	logic [KEY_W-1:0]  khi_q;
	logic [VAL_W-1:0]  vlo_q;
	logic [VAL_W-1:0]  vhi_q;
	logic [KEY_W-1:0]  step_q;
	logic [KEY_W-1:0]  off_q;
	logic [NUM_W-1:0]  prod_q;
	logic [KEY_W-1:0]  rem_q;
	logic [VAL_W-1:0]  quo_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic [VAL_W-1:0]  value_q;
	logic [ST_W-1:0]   status_q;

	logic [KEY_W-1:0]  step_c;
	logic [KEY_W-1:0]  off_raw;
	logic [KEY_W-1:0]  off_c;
	logic [NUM_W-1:0]  prod_c;
	logic [NUM_W-1:0]  num_c;
	logic [KEY_W:0]    trial;
	logic              trial_ge;

	assign rd_key    = rd_q[WORD_W-1:VAL_W];
	assign rd_val    = rd_q[VAL_W-1:0];
	assign last_addr = AW'(count_q - CW'(1));
	assign mid       = AW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);

	always_comb begin
		unique case (cmd.addr_sel)
			ADDR_FIRST: rd_addr = '0;
			ADDR_LAST:  rd_addr = last_addr;
			ADDR_MID:   rd_addr = mid;
			ADDR_LO:    rd_addr = lo_q;
			ADDR_HI:    rd_addr = hi_q;
			default:    rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_APPEND) begin
			mem[count_q[AW-1:0]] <= {t_q, v_q};
		end
		rd_q <= mem[rd_addr];
	end

	assign step_c   = khi_q - klo_q;
	assign off_raw  = (t_q > klo_q) ? (t_q - klo_q) : '0;
	assign off_c    = (off_raw > step_c) ? step_c : off_raw;
	assign prod_c   = NUM_W'(vlo_q) * NUM_W'(step_q - off_q);
	assign num_c    = prod_q + NUM_W'(vhi_q) * NUM_W'(off_q);
	assign trial    = {rem_q, quo_q[VAL_W-1]};
	assign trial_ge = trial >= {1'b0, step_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q   <= LOW_HOLD_RESET;
			high_q  <= HIGH_HOLD_RESET;
			count_q <= '0;
			miss_q  <= '0;
		end else begin
			if (wr_en) begin
				if (wr_index == REG_LOW_HOLD) begin
					low_q <= wr_data;
				end else begin
					high_q <= wr_data;
				end
			end
			if (cmd.op == OP_CLEAR) begin
				count_q <= '0;
			end else if (cmd.op == OP_APPEND) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.op == OP_BUMP && miss_q != '1) begin
				miss_q <= miss_q + KEY_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LATCH: begin
				action_q <= action;
				t_q      <= temperature;
				v_q      <= entry_value;
			end
			OP_INIT: begin
				lo_q <= '0;
				hi_q <= last_addr;
			end
			OP_STEP: begin
				if (t_q <= rd_key) begin
					hi_q <= mid;
				end else begin
					lo_q <= mid;
				end
			end
			OP_LOAD_LO: begin
				klo_q <= rd_key;
				vlo_q <= rd_val;
			end
			OP_LOAD_HI: begin
				khi_q <= rd_key;
				vhi_q <= rd_val;
			end
			OP_PREP: begin
				step_q <= step_c;
				off_q  <= off_c;
			end
			OP_MUL1: begin
				prod_q <= prod_c;
			end
			OP_MUL2: begin
				rem_q  <= num_c[NUM_W-1:VAL_W];
				quo_q  <= num_c[VAL_W-1:0];
				dcnt_q <= '0;
			end
			OP_DIV_STEP: begin
				if (trial_ge) begin
					rem_q <= KEY_W'(trial - {1'b0, step_q});
				end else begin
					rem_q <= trial[KEY_W-1:0];
				end
				quo_q  <= {quo_q[VAL_W-2:0], trial_ge};
				dcnt_q <= dcnt_q + DCNT_W'(1);
			end
			default: begin
			end
		endcase
		if (cmd.finish) begin
			status_q <= cmd.res_status;
			unique case (cmd.val_sel)
				VAL_ZERO: value_q <= '0;
				VAL_RD:   value_q <= rd_val;
				VAL_LO:   value_q <= vlo_q;
				VAL_QUOT: value_q <= quo_q;
				default:  value_q <= '0;
			endcase
		end
	end

	always_comb begin
		stat.action      = action_q;
		stat.n_zero      = count_q == '0;
		stat.n_one       = count_q == CW'(1);
		stat.full        = count_q == CW'(TABLE_DEPTH);
		stat.t_gt_high   = t_q > high_q;
		stat.t_lt_low    = t_q < low_q;
		stat.t_gt_key    = t_q > rd_key;
		stat.t_lt_key    = t_q < rd_key;
		stat.search_done = ({1'b0, lo_q} + {{AW{1'b0}}, 1'b1}) == {1'b0, hi_q};
		stat.step_nonpos = khi_q <= klo_q;
		stat.div_last    = dcnt_q == DCNT_W'(VAL_W - 1);
	end

	assign value_out          = value_q;
	assign status             = status_q;
	assign out_of_range_count = miss_q;

endmodule

`default_nettype wire

>>> src/tia_ctrl.sv
// Controller: sequences clear, append and query items over the datapath.
// Issues tia_cmd_t and reads tia_stat_t; owns busy and done. Uses tia_pkg.
`default_nettype none

module tia_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	output logic                busy,
	output logic                done,
	output tia_pkg::tia_cmd_t   cmd,
	input  tia_pkg::tia_stat_t  stat
);
	import tia_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_HOLD_RD,
		S_CHK_LAST,
		S_CHK_FIRST,
		S_SEARCH,
		S_STEP,
		S_LOAD_LO,
		S_LOAD_HI,
		S_CHK_STEP,
		S_MUL1,
		S_MUL2,
		S_DIV,
		S_FIN_DIV
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   busy_q;
	logic   done_q;

	always_comb begin
		state_d        = state_q;
		cmd.op         = OP_NONE;
		cmd.addr_sel   = ADDR_FIRST;
		cmd.finish     = 1'b0;
		cmd.res_status = ST_INTERP;
		cmd.val_sel    = VAL_ZERO;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.op  = OP_LATCH;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				priority if (stat.action == ACT_CLEAR) begin
					cmd.op         = OP_CLEAR;
					cmd.finish     = 1'b1;
					cmd.res_status = ST_CLEARED;
					state_d        = S_IDLE;
				end else if (stat.action == ACT_APPEND) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
					if (stat.full) begin
						cmd.res_status = ST_FULL;
					end else begin
						cmd.op         = OP_APPEND;
						cmd.res_status = ST_STORED;
					end
				end else begin
					priority if (stat.n_zero) begin
						cmd.finish     = 1'b1;
						cmd.res_status = ST_EMPTY;
						state_d        = S_IDLE;
					end else if (stat.t_gt_high) begin
						cmd.addr_sel = ADDR_LAST;
						state_d      = S_HOLD_RD;
					end else if (stat.t_lt_low) begin
						cmd.addr_sel = ADDR_FIRST;
						state_d      = S_HOLD_RD;
					end else begin
						cmd.addr_sel = ADDR_LAST;
						state_d      = S_CHK_LAST;
					end
				end
			end
			S_HOLD_RD: begin
				cmd.finish     = 1'b1;
				cmd.res_status = ST_HOLD;
				cmd.val_sel    = VAL_RD;
				state_d        = S_IDLE;
			end
			S_CHK_LAST: begin
				if (stat.t_gt_key) begin
					cmd.op         = OP_BUMP;
					cmd.finish     = 1'b1;
					cmd.res_status = ST_OUTSIDE;
					cmd.val_sel    = VAL_RD;
					state_d        = S_IDLE;
				end else begin
					cmd.addr_sel = ADDR_FIRST;
					state_d      = S_CHK_FIRST;
				end
			end
			S_CHK_FIRST: begin
				priority if (stat.t_lt_key) begin
					cmd.op         = OP_BUMP;
					cmd.finish     = 1'b1;
					cmd.res_status = ST_OUTSIDE;
					cmd.val_sel    = VAL_RD;
					state_d        = S_IDLE;
				end else if (stat.n_one) begin
					cmd.finish     = 1'b1;
					cmd.res_status = ST_INTERP;
					cmd.val_sel    = VAL_RD;
					state_d        = S_IDLE;
				end else begin
					cmd.op  = OP_INIT;
					state_d = S_SEARCH;
				end
			end
			S_SEARCH: begin
				if (stat.search_done) begin
					cmd.addr_sel = ADDR_LO;
					state_d      = S_LOAD_LO;
				end else begin
					cmd.addr_sel = ADDR_MID;
					state_d      = S_STEP;
				end
			end
			S_STEP: begin
				cmd.op  = OP_STEP;
				state_d = S_SEARCH;
			end
			S_LOAD_LO: begin
				cmd.op       = OP_LOAD_LO;
				cmd.addr_sel = ADDR_HI;
				state_d      = S_LOAD_HI;
			end
			S_LOAD_HI: begin
				cmd.op  = OP_LOAD_HI;
				state_d = S_CHK_STEP;
			end
			S_CHK_STEP: begin
				cmd.op = OP_PREP;
				if (stat.step_nonpos) begin
					cmd.finish     = 1'b1;
					cmd.res_status = ST_INTERP;
					cmd.val_sel    = VAL_LO;
					state_d        = S_IDLE;
				end else begin
					state_d = S_MUL1;
				end
			end
			S_MUL1: begin
				cmd.op  = OP_MUL1;
				state_d = S_MUL2;
			end
			S_MUL2: begin
				cmd.op  = OP_MUL2;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.op = OP_DIV_STEP;
				if (stat.div_last) begin
					state_d = S_FIN_DIV;
				end
			end
			S_FIN_DIV: begin
				cmd.finish     = 1'b1;
				cmd.res_status = ST_INTERP;
				cmd.val_sel    = VAL_QUOT;
				state_d        = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= state_d != S_IDLE;
			done_q  <= cmd.finish;
		end
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

`default_nettype wire

>>> src/table_interp_binary_search.sv
// Table interpolation with binary search: clear, append and query on a stored key/value table.
// A query that interpolates runs a binary search, with one table read per search step, and
// then a 16-step serial divider, which a zero step skips; clear, append and the other
// queries end without either. One item at a time, next start taken at the done transfer.
// Reset zeroes entry count and miss counter, restores hold thresholds. Uses tia_ctrl, tia_dpath.
`default_nettype none

module table_interp_binary_search (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	output logic        done,
	input  wire  [1:0]  action,
	input  wire  [31:0] temperature,
	input  wire  [15:0] entry_value,
	input  wire         wr_en,
	input  wire         wr_index,
	input  wire  [31:0] wr_data,
	output logic [15:0] value_out,
	output logic [2:0]  status,
	output logic [31:0] out_of_range_count
);
	import tia_pkg::*;

	tia_cmd_t  cmd;
	tia_stat_t stat;

	tia_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.stat   (stat)
	);

	tia_dpath u_dpath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.stat               (stat),
		.action             (action),
		.temperature        (temperature),
		.entry_value        (entry_value),
		.wr_en              (wr_en),
		.wr_index           (wr_index),
		.wr_data            (wr_data),
		.value_out          (value_out),
		.status             (status),
		.out_of_range_count (out_of_range_count)
	);

endmodule

`default_nettype wire

>>> test/table_interp_binary_search_checker.sv
`timescale 1ns / 1ps
// Result checker for table_interp_binary_search: mirrors the key/value table, the hold
// thresholds and the miss counter, predicts each lookup and compares every result transfer.
// Depends on tia_pkg.

module table_interp_binary_search_checker (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	input  wire         busy,
	input  wire  [1:0]  action,
	input  wire  [31:0] temperature,
	input  wire  [15:0] entry_value,
	input  wire         wr_en,
	input  wire         wr_index,
	input  wire  [31:0] wr_data,
	input  wire         done,
	input  wire  [15:0] value_out,
	input  wire  [2:0]  status,
	input  wire  [31:0] out_of_range_count,
	output int          fails,
	output int          pending
);
	import tia_pkg::*;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic [ST_W-1:0]  stat;
		logic [31:0]      misses;
	} lookup_result_t;

	logic [KEY_W-1:0] keys [TABLE_DEPTH];
	logic [VAL_W-1:0] vals [TABLE_DEPTH];
	int unsigned      n_entries;
	logic [31:0]      miss_count;
	logic [KEY_W-1:0] low_hold;
	logic [KEY_W-1:0] high_hold;
	lookup_result_t   awaited [$];

	function automatic lookup_result_t lookup(input logic [KEY_W-1:0] t);
		lookup_result_t r;
		int unsigned    lo, hi, mid;
		logic [31:0]    klo, khi, span, off;
		logic [63:0]    wlo, whi, wspan, woff, num;
		r = '0;
		if (n_entries == 0) begin
			r.stat = ST_EMPTY;
			return r;
		end
		if (t > high_hold) begin
			r.stat = ST_HOLD;
			r.value = vals[n_entries - 1];
			return r;
		end
		if (t < low_hold) begin
			r.stat = ST_HOLD;
			r.value = vals[0];
			return r;
		end
		if (t > keys[n_entries - 1]) begin
			r.stat = ST_OUTSIDE;
			r.value = vals[n_entries - 1];
			return r;
		end
		if (t < keys[0]) begin
			r.stat = ST_OUTSIDE;
			r.value = vals[0];
			return r;
		end
		r.stat = ST_INTERP;
		if (n_entries == 1) begin
			r.value = vals[0];
			return r;
		end
		lo = 0;
		hi = n_entries - 1;
		while (lo + 1 != hi) begin
			mid = (lo + hi) >> 1;
			if (t <= keys[mid]) begin
				hi = mid;
			end else begin
				lo = mid;
			end
		end
		klo = keys[lo];
		khi = keys[hi];
		if (khi <= klo) begin
			r.value = vals[lo];
			return r;
		end
		span = khi - klo;
		off = (t > klo) ? t - klo : '0;
		if (off > span) begin
			off = span;
		end
		wlo = 64'(vals[lo]);
		whi = 64'(vals[hi]);
		wspan = 64'(span);
		woff = 64'(off);
		num = wlo * (wspan - woff) + whi * woff;
		r.value = VAL_W'(num / wspan);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		lookup_result_t want;
		if (!arst_n) begin
			n_entries = 0;
			miss_count = '0;
			low_hold = LOW_HOLD_RESET;
			high_hold = HIGH_HOLD_RESET;
			awaited.delete();
			pending = 0;
		end else begin
			if (wr_en) begin
				if (wr_index == REG_LOW_HOLD) begin
					low_hold = wr_data;
				end else begin
					high_hold = wr_data;
				end
			end
			if (done) begin
				if (awaited.size() == 0) begin
					fails++;
					if (fails <= 10) begin
						$display("%0t: result with none awaited: value %h status %0d count %0d",
							$realtime, value_out, status, out_of_range_count);
					end
				end else begin
					want = awaited.pop_front();
					if (value_out !== want.value || status !== want.stat ||
							out_of_range_count !== want.misses) begin
						fails++;
						if (fails <= 10) begin
							$display("%0t: exp value %h status %0d count %0d, got %h %0d %0d",
								$realtime, want.value, want.stat, want.misses,
								value_out, status, out_of_range_count);
						end
					end
				end
			end
			if (start && !busy) begin
				want = '0;
				case (action)
					ACT_CLEAR: begin
						n_entries = 0;
						want.stat = ST_CLEARED;
					end
					ACT_APPEND: begin
						if (n_entries < TABLE_DEPTH) begin
							keys[n_entries] = temperature;
							vals[n_entries] = entry_value;
							n_entries++;
							want.stat = ST_STORED;
						end else begin
							want.stat = ST_FULL;
						end
					end
					default: begin
						want = lookup(temperature);
						if (want.stat == ST_OUTSIDE && miss_count != '1) begin
							miss_count++;
						end
					end
				endcase
				want.misses = miss_count;
				awaited.push_back(want);
			end
			pending = awaited.size();
		end
	end

endmodule

>>> test/table_interp_binary_search_tb.sv
`timescale 1ns / 1ps
// Top of the table_interp_binary_search regression: clock, reset, threshold writes and
// clear/append/query stimulus with sender gaps; verdict from checker fails and pending.
// Depends on tia_pkg, table_interp_binary_search and table_interp_binary_search_checker.

module table_interp_binary_search_tb;
	import tia_pkg::*;

	localparam logic [ACT_W-1:0] ACT_QUERY_ALT = 2'd3;
	localparam int QUIET_LIMIT       = 2000;
	localparam int SETTLE_CYCLES     = 64;
	localparam int ITEMS_PER_SETTING = 88;
	localparam int SETTINGS_COUNT    = 6;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [1:0]  action = '0;
	logic [31:0] temperature = '0;
	logic [15:0] entry_value = '0;
	logic        wr_en = 1'b0;
	logic        wr_index = 1'b0;
	logic [31:0] wr_data = '0;
	wire         busy;
	wire         done;
	wire  [15:0] value_out;
	wire  [2:0]  status;
	wire  [31:0] out_of_range_count;
	int          fails;
	int          pending;
	int          sent = 0;
	int          settings_used = 0;
	int          quiet = 0;
	int          idle_pct = 0;
	logic [31:0] loaded_keys [$];
	logic [31:0] low_now = LOW_HOLD_RESET;
	logic [31:0] high_now = HIGH_HOLD_RESET;

	table_interp_binary_search dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.start              (start),
		.busy               (busy),
		.done               (done),
		.action             (action),
		.temperature        (temperature),
		.entry_value        (entry_value),
		.wr_en              (wr_en),
		.wr_index           (wr_index),
		.wr_data            (wr_data),
		.value_out          (value_out),
		.status             (status),
		.out_of_range_count (out_of_range_count)
	);

	table_interp_binary_search_checker lookup_check (
		.clk                (clk),
		.arst_n             (arst_n),
		.start              (start),
		.busy               (busy),
		.action             (action),
		.temperature        (temperature),
		.entry_value        (entry_value),
		.wr_en              (wr_en),
		.wr_index           (wr_index),
		.wr_data            (wr_data),
		.done               (done),
		.value_out          (value_out),
		.status             (status),
		.out_of_range_count (out_of_range_count),
		.fails              (fails),
		.pending            (pending)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
		end
		if (quiet >= QUIET_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", quiet);
			$display("table_interp_binary_search regression: fail");
			$finish;
		end
	end

	task automatic issue(input logic [1:0] a, input logic [31:0] t, input logic [15:0] v);
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 40)) @(posedge clk);
		end
		start <= 1'b1;
		action <= a;
		temperature <= t;
		entry_value <= v;
		do @(posedge clk); while (busy);
		if (a == ACT_CLEAR) begin
			loaded_keys.delete();
		end else if (a == ACT_APPEND && loaded_keys.size() < TABLE_DEPTH) begin
			loaded_keys.push_back(t);
		end
		sent++;
	endtask

	// drain: hold start low until every result is back, then let the block go quiet
	task automatic settle();
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_holds(input logic [31:0] lo, input logic [31:0] hi);
		wr_en <= 1'b1;
		wr_index <= REG_LOW_HOLD;
		wr_data <= lo;
		@(posedge clk);
		wr_index <= REG_HIGH_HOLD;
		wr_data <= hi;
		@(posedge clk);
		wr_en <= 1'b0;
		low_now = lo;
		high_now = hi;
		settings_used++;
	endtask

	function automatic logic [31:0] probe_temp();
		logic [31:0] first, last;
		int          pick;
		if (loaded_keys.size() == 0) begin
			return $urandom;
		end
		first = loaded_keys[0];
		last = loaded_keys[loaded_keys.size() - 1];
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			return $urandom_range(first, last);
		end
		if (pick < 65) begin
			return loaded_keys[$urandom_range(0, loaded_keys.size() - 1)];
		end
		if (pick < 75) begin
			return first - 32'd1;
		end
		if (pick < 85) begin
			return last + 32'd1;
		end
		if (pick < 92) begin
			return $urandom;
		end
		case ($urandom_range(0, 3))
			0: return low_now - 32'd1;
			1: return low_now;
			2: return high_now;
			default: return high_now + 32'd1;
		endcase
	endfunction

	task automatic table_sequence();
		int          n_new, n_probe, i;
		logic [31:0] k, step, span_max;
		bit          shuffled;
		if ($urandom_range(0, 9) != 0) begin
			issue(ACT_CLEAR, $urandom, 16'($urandom));
		end
		n_new = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 12);
		shuffled = ($urandom_range(0, 6) == 0);
		span_max = 32'd1 << $urandom_range(0, 26);
		k = $urandom_range(0, 1) ? $urandom : $urandom_range(0, high_now);
		for (i = 0; i < n_new; i++) begin
			issue(ACT_APPEND, shuffled ? $urandom : k, 16'($urandom));
			step = $urandom_range(0, span_max);
			k = (k > 32'hFFFF_FFFF - step) ? 32'hFFFF_FFFF : k + step;
		end
		n_probe = $urandom_range(2, 10);
		for (i = 0; i < n_probe; i++) begin
			issue(($urandom_range(0, 4) == 0) ? ACT_QUERY_ALT : ACT_QUERY, probe_temp(),
				16'($urandom));
		end
	endtask

	initial begin : stimulus
		int          s, target, random_from;
		logic [31:0] k, mid_hold;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(ACT_QUERY, 32'd3_000_000, 16'hFFFF);
		issue(ACT_QUERY_ALT, 32'hFFFF_FFFF, 16'h0000);
		issue(ACT_CLEAR, 32'hFFFF_FFFF, 16'hFFFF);
		issue(ACT_APPEND, 32'd3_000_000, 16'h1000);
		issue(ACT_QUERY, 32'd3_000_000, 16'h0000);
		issue(ACT_QUERY, 32'd2_999_999, 16'h0000);
		issue(ACT_QUERY, 32'd3_000_001, 16'h0000);
		issue(ACT_QUERY, 32'd0, 16'h0000);
		issue(ACT_QUERY, 32'hFFFF_FFFF, 16'h0000);
		issue(ACT_APPEND, 32'd4_000_000, 16'hFFFF);
		issue(ACT_APPEND, 32'd4_000_000, 16'h0000);
		issue(ACT_APPEND, 32'd8_000_000, 16'h8000);
		issue(ACT_QUERY, 32'd3_500_000, 16'h0000);
		issue(ACT_QUERY, 32'd4_000_000, 16'h0000);
		issue(ACT_QUERY_ALT, 32'd5_000_000, 16'h0000);
		issue(ACT_APPEND, 32'd6_000_000, 16'h2000);
		issue(ACT_QUERY, 32'd7_999_999, 16'h0000);
		issue(ACT_QUERY, 32'd6_500_000, 16'h0000);
		issue(ACT_CLEAR, 32'd0, 16'h0000);
		issue(ACT_APPEND, 32'd5_000_000, 16'h0100);
		issue(ACT_APPEND, 32'd5_000_000, 16'h0200);
		issue(ACT_APPEND, 32'd9_000_000, 16'h0300);
		issue(ACT_QUERY, 32'd5_000_000, 16'h0000);
		issue(ACT_APPEND, 32'hFFFF_FFFF, 16'hFFFF);
		issue(ACT_QUERY, HIGH_HOLD_RESET, 16'h0000);

		random_from = sent;
		for (s = 0; s < SETTINGS_COUNT; s++) begin
			settle();
			case (s)
				0, 4: begin
					k = $urandom_range(0, 32'h0800_0000);
					set_holds(k, k + $urandom_range(0, 32'h4000_0000));
				end
				1, 5: set_holds(32'd0, 32'hFFFF_FFFF);
				2: set_holds(32'hFFFF_FFFF, 32'd0);
				default: begin
					mid_hold = $urandom;
					set_holds(mid_hold, mid_hold);
				end
			endcase
			idle_pct = (s < 2) ? 7 : (s < 4) ? 55 : 0;
			target = sent + ITEMS_PER_SETTING;
			while (sent < target) begin
				if ($urandom_range(0, 9) == 0) begin
					repeat ($urandom_range(1, 4)) begin
						issue(2'($urandom_range(0, 3)), $urandom, 16'($urandom));
					end
				end else begin
					table_sequence();
				end
			end
		end
		settle();

		$display("covered %0d transfers, %0d of them random, across %0d threshold settings",
			sent, sent - random_from, settings_used);
		$display("sorted, duplicate and shuffled tables probed at holds, ends and inside spans");
		if (fails == 0 && pending == 0) begin
			$display("table_interp_binary_search regression: pass");
		end else begin
			$display("table_interp_binary_search regression: fail");
		end
		$finish;
	end

endmodule

>>> table_interp_binary_search.f
src/tia_pkg.sv
src/tia_dpath.sv
src/tia_ctrl.sv
src/table_interp_binary_search.sv
test/table_interp_binary_search_checker.sv
test/table_interp_binary_search_tb.sv
